### design/sll_pkg.sv
// Shared types, constants and helper functions for the linked list engine.
// Used by the controller, the datapath and the top level.
// No dependencies.
`timescale 1ns / 1ps

package sll_pkg;

   // Node pool size and derived widths. A pointer equal to NODES is null.
   localparam int NODES    = 256;
   localparam int ADDR_W   = $clog2(NODES);
   localparam int PTR_W    = $clog2(NODES + 1);
   localparam int DATA_W   = 32;
   localparam int OP_W     = 4;
   localparam int STATUS_W = 2;

   localparam logic [PTR_W-1:0] NIL_PTR = PTR_W'(NODES);

   // Packed widths of the stream payloads.
   localparam int REQ_TDATA_W   = ((DATA_W + 7) / 8) * 8;
   localparam int REQ_TUSER_W   = ((OP_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W  = DATA_W + STATUS_W + 3;
   localparam int RSP_TDATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Request codes.
   typedef enum logic [OP_W-1:0] {
      OP_CLEAR          = 4'd0,
      OP_INSERT_HEAD    = 4'd1,
      OP_CURSOR_TO_HEAD = 4'd2,
      OP_DELETE_HEAD    = 4'd3,
      OP_DELETE_AFTER   = 4'd4,
      OP_INSERT_AFTER   = 4'd5,
      OP_OVERWRITE      = 4'd6,
      OP_ADVANCE        = 4'd7,
      OP_READ_HEAD      = 4'd8,
      OP_READ_CURSOR    = 4'd9
   } req_op_type;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      STAT_OK         = 2'd0,
      STAT_POOL_FULL  = 2'd1,
      STAT_EMPTY_HEAD = 2'd2,
      STAT_NO_CURSOR  = 2'd3
   } rsp_status_type;

   // Controller states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_READ1,
      S_READ2,
      S_COMMIT1,
      S_COMMIT2,
      S_RESULT
   } ctrl_state_type;

   // Result fields, read_value in the lowest bits.
   typedef struct packed {
      logic                       sticky_error;
      logic                       list_empty;
      logic                       cursor_active;
      rsp_status_type             status;
      logic signed [DATA_W-1:0]   read_value;
   } rsp_fields_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic read1;
      logic read2;
      logic commit1;
      logic commit2;
      logic load_now;
      logic load_held;
   } sll_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      req_op_type op;
      logic       out_free;
   } sll_stat_type;

   // A pointer addresses a node when it is below the pool size.
   function automatic logic is_node(input logic [PTR_W-1:0] p);
      return p < NIL_PTR;
   endfunction

   // Any out-of-range pointer reads as null.
   function automatic logic [PTR_W-1:0] mask_ptr(input logic [PTR_W-1:0] p);
      return is_node(p) ? p : NIL_PTR;
   endfunction

   // Memory address of a pointer; null maps to entry zero and is never used.
   function automatic logic [ADDR_W-1:0] ptr_addr(input logic [PTR_W-1:0] p);
      return is_node(p) ? p[ADDR_W-1:0] : '0;
   endfunction

   // Requests that need a memory read before they commit.
   function automatic logic needs_read(input req_op_type op);
      logic r;
      unique case (op)
         OP_INSERT_HEAD, OP_DELETE_HEAD, OP_DELETE_AFTER, OP_INSERT_AFTER,
         OP_ADVANCE, OP_READ_HEAD, OP_READ_CURSOR: r = 1'b1;
         default:                                  r = 1'b0;
      endcase
      return r;
   endfunction

   // Requests that take two link reads and two link writes.
   function automatic logic two_step(input req_op_type op);
      return (op == OP_DELETE_AFTER) || (op == OP_INSERT_AFTER);
   endfunction

endpackage

### design/singly_linked_list_engine_core.sv
// Singly linked list engine with a head pointer and one cursor over a fixed
// node pool; each request item yields exactly one result item. Clear,
// cursor_to_head, overwrite and unused codes go straight to the main commit;
// insert_head, delete_head, advance and the reads take one read phase first,
// and delete_after and insert_after take two link reads and two commits. A
// finished request waits in the result state while the output register is full.
// These phases come from the registered read port of the node link store and
// its single write port: the two requests that touch the cursor's successor
// need two link reads and two link writes. The result register lets a new
// request be taken while the previous result waits. Node stores are not
// cleared at reset, so there is no startup pass; clear resets only the pointers
// and the allocator. Depends on sll_pkg, sll_ctrl, sll_datapath and sll_ram.
`timescale 1ns / 1ps

module singly_linked_list_engine_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [sll_pkg::REQ_TDATA_W-1:0]  req_tdata,   // value [31:0]
   input  logic [sll_pkg::REQ_TUSER_W-1:0]  req_tuser,   // req_type [3:0], zero fill above
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // read_value [31:0], status [33:32], cursor_active [34], list_empty [35],
   // sticky_error [36], zero fill above
   output logic [sll_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import sll_pkg::*;

   sll_cmd_type  cmd;
   sll_stat_type stat;

   sll_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   sll_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### design/sll_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the node data and node link stores. No dependencies.
`timescale 1ns / 1ps

module sll_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/sll_ctrl.sv
// Sequencer for the linked list engine: walks each request through its
// read and commit phases. Depends on sll_pkg.
`timescale 1ns / 1ps

module sll_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic [sll_pkg::REQ_TUSER_W-1:0]    req_tuser,   // req_type [3:0]
   output logic                               req_tready,
   input  sll_pkg::sll_stat_type              stat,
   output sll_pkg::sll_cmd_type               cmd
);
   import sll_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   req_op_type     new_op;

   assign new_op = req_op_type'(req_tuser[OP_W-1:0]);

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = needs_read(new_op) ? S_READ1 : S_COMMIT1;
            end
         end
         S_READ1: begin
            cmd.read1 = 1'b1;
            state_in  = two_step(stat.op) ? S_READ2 : S_COMMIT1;
         end
         S_READ2: begin
            cmd.read2 = 1'b1;
            state_in  = S_COMMIT1;
         end
         S_COMMIT1: begin
            cmd.commit1 = 1'b1;
            if (two_step(stat.op)) begin
               state_in = S_COMMIT2;
            end else if (stat.out_free) begin
               cmd.load_now = 1'b1;
               state_in     = S_IDLE;
            end else begin
               state_in = S_RESULT;
            end
         end
         S_COMMIT2: begin
            cmd.commit2 = 1'b1;
            if (stat.out_free) begin
               cmd.load_held = 1'b1;
               state_in      = S_IDLE;
            end else begin
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (stat.out_free) begin
               cmd.load_held = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

### design/sll_datapath.sv
// Datapath of the linked list engine: pointer registers, node stores,
// node allocation and the result register. Depends on sll_pkg and sll_ram.
`timescale 1ns / 1ps

module sll_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  sll_pkg::sll_cmd_type             cmd,
   output sll_pkg::sll_stat_type            stat,
   input  logic [sll_pkg::REQ_TDATA_W-1:0]  req_tdata,   // value [31:0]
   input  logic [sll_pkg::REQ_TUSER_W-1:0]  req_tuser,   // req_type [3:0]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // read_value [31:0], status [33:32], cursor_active [34], list_empty [35],
   // sticky_error [36], zero fill above
   output logic [sll_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import sll_pkg::*;

   // Request payload.
   req_op_type               op_ff, op_in;
   logic signed [DATA_W-1:0] val_ff, val_in;

   // List state.
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] cur_ff, cur_in;
   logic [PTR_W-1:0] free_ff, free_in;
   logic [PTR_W-1:0] fresh_ff, fresh_in;
   logic             err_ff, err_in;

   // Scratch pointers between phases.
   logic [PTR_W-1:0] tmp_ff, tmp_in;
   logic [PTR_W-1:0] new_ff, new_in;

   // Result held for a later load, and the output register.
   rsp_fields_type           held_ff, held_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0]   rsp_data_ff, rsp_data_in;

   // Memory ports.
   logic              link_we;
   logic [ADDR_W-1:0] link_waddr;
   logic [PTR_W-1:0]  link_wdata;
   logic [ADDR_W-1:0] link_raddr;
   logic [PTR_W-1:0]  link_rd;
   logic              data_we;
   logic [ADDR_W-1:0] data_waddr;
   logic [ADDR_W-1:0] data_raddr;
   logic [DATA_W-1:0] data_rd;

   // Commit helpers.
   logic [PTR_W-1:0]         link_rd_m;
   logic                     free_ok;
   logic                     fresh_ok;
   logic [PTR_W-1:0]         take_p;
   logic [PTR_W-1:0]         free_next;
   logic signed [DATA_W-1:0] rd_v;
   rsp_status_type           status_v;
   rsp_fields_type           now_res;

   sll_ram #(
      .WIDTH (DATA_W),
      .DEPTH (NODES)
   ) u_data_ram (
      .clock   (clock),
      .wr_en   (data_we),
      .wr_addr (data_waddr),
      .wr_data (val_ff),
      .rd_addr (data_raddr),
      .rd_data (data_rd)
   );

   sll_ram #(
      .WIDTH (PTR_W),
      .DEPTH (NODES)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_addr (link_raddr),
      .rd_data (link_rd)
   );

   assign link_rd_m = mask_ptr(link_rd);

   // Node allocation: free list first, then never-used nodes.
   assign free_ok   = is_node(free_ff);
   assign fresh_ok  = fresh_ff < NIL_PTR;
   assign take_p    = free_ok ? free_ff : (fresh_ok ? fresh_ff : NIL_PTR);
   assign free_next = (op_ff == OP_INSERT_HEAD) ? link_rd_m : tmp_ff;

   // Read addresses, phase updates and memory writes.
   always_comb begin
      op_in        = op_ff;
      val_in       = val_ff;
      head_in      = head_ff;
      cur_in       = cur_ff;
      free_in      = free_ff;
      fresh_in     = fresh_ff;
      err_in       = err_ff;
      tmp_in       = tmp_ff;
      new_in       = new_ff;
      link_we      = 1'b0;
      link_waddr   = '0;
      link_wdata   = NIL_PTR;
      link_raddr   = '0;
      data_we      = 1'b0;
      data_waddr   = '0;
      rd_v         = '0;
      status_v     = STAT_OK;
      data_raddr   = (op_ff == OP_READ_HEAD) ? ptr_addr(head_ff) : ptr_addr(cur_ff);

      if (cmd.accept) begin
         op_in  = req_op_type'(req_tuser[OP_W-1:0]);
         val_in = signed'(req_tdata[DATA_W-1:0]);
      end

      // First read: the free list head, the head or the cursor node.
      if (cmd.read1) begin
         unique case (op_ff)
            OP_INSERT_HEAD, OP_INSERT_AFTER: link_raddr = ptr_addr(free_ff);
            OP_DELETE_HEAD:                  link_raddr = ptr_addr(head_ff);
            default:                         link_raddr = ptr_addr(cur_ff);
         endcase
      end

      // Second read: the node after the cursor's successor, or the cursor's link.
      if (cmd.read2) begin
         tmp_in = link_rd_m;
         if (op_ff == OP_DELETE_AFTER) begin
            link_raddr = ptr_addr(link_rd_m);
         end else begin
            link_raddr = ptr_addr(cur_ff);
         end
      end

      // Main commit: pointer updates, at most one link write and at most one data write.
      if (cmd.commit1) begin
         unique case (op_ff)
            OP_CLEAR: begin
               head_in  = NIL_PTR;
               cur_in   = NIL_PTR;
               free_in  = NIL_PTR;
               fresh_in = '0;
            end
            OP_INSERT_HEAD: begin
               if (is_node(take_p)) begin
                  data_we    = 1'b1;
                  data_waddr = ptr_addr(take_p);
                  link_we    = 1'b1;
                  link_waddr = ptr_addr(take_p);
                  link_wdata = head_ff;
                  head_in    = take_p;
                  if (free_ok) begin
                     free_in = free_next;
                  end else begin
                     fresh_in = fresh_ff + PTR_W'(1);
                  end
               end else begin
                  status_v = STAT_POOL_FULL;
               end
            end
            OP_CURSOR_TO_HEAD: begin
               cur_in = head_ff;
            end
            OP_DELETE_HEAD: begin
               if (is_node(head_ff)) begin
                  if (cur_ff == head_ff) begin
                     cur_in = NIL_PTR;
                  end
                  link_we    = 1'b1;
                  link_waddr = ptr_addr(head_ff);
                  link_wdata = free_ff;
                  free_in    = head_ff;
                  head_in    = link_rd_m;
               end
            end
            OP_DELETE_AFTER: begin
               // Unlink the successor; it joins the free list in the next phase.
               if (is_node(cur_ff) && is_node(tmp_ff)) begin
                  link_we    = 1'b1;
                  link_waddr = ptr_addr(cur_ff);
                  link_wdata = link_rd_m;
               end
            end
            OP_INSERT_AFTER: begin
               new_in = NIL_PTR;
               if (is_node(cur_ff)) begin
                  if (is_node(take_p)) begin
                     data_we    = 1'b1;
                     data_waddr = ptr_addr(take_p);
                     link_we    = 1'b1;
                     link_waddr = ptr_addr(take_p);
                     link_wdata = link_rd_m;
                     new_in     = take_p;
                     if (free_ok) begin
                        free_in = free_next;
                     end else begin
                        fresh_in = fresh_ff + PTR_W'(1);
                     end
                  end else begin
                     status_v = STAT_POOL_FULL;
                  end
               end
            end
            OP_OVERWRITE: begin
               if (is_node(cur_ff)) begin
                  data_we    = 1'b1;
                  data_waddr = ptr_addr(cur_ff);
               end
            end
            OP_ADVANCE: begin
               if (is_node(cur_ff)) begin
                  cur_in = link_rd_m;
               end
            end
            OP_READ_HEAD: begin
               if (is_node(head_ff)) begin
                  rd_v = signed'(data_rd);
               end else begin
                  status_v = STAT_EMPTY_HEAD;
               end
            end
            OP_READ_CURSOR: begin
               if (is_node(cur_ff)) begin
                  rd_v = signed'(data_rd);
               end else begin
                  status_v = STAT_NO_CURSOR;
               end
            end
            default: begin
            end
         endcase
         err_in  = err_ff | (status_v != STAT_OK);
      end

      // Second commit: the link write left over by the two-step requests.
      if (cmd.commit2) begin
         unique case (op_ff)
            OP_DELETE_AFTER: begin
               if (is_node(cur_ff) && is_node(tmp_ff)) begin
                  link_we    = 1'b1;
                  link_waddr = ptr_addr(tmp_ff);
                  link_wdata = free_ff;
                  free_in    = tmp_ff;
               end
            end
            OP_INSERT_AFTER: begin
               if (is_node(cur_ff) && is_node(new_ff)) begin
                  link_we    = 1'b1;
                  link_waddr = ptr_addr(cur_ff);
                  link_wdata = new_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Result of the request as it commits, kept for a later load.
   always_comb begin
      now_res.read_value    = rd_v;
      now_res.status        = status_v;
      now_res.cursor_active = is_node(cur_in);
      now_res.list_empty    = !is_node(head_in);
      now_res.sticky_error  = err_in;
      held_in               = cmd.commit1 ? now_res : held_ff;
   end

   // Output register: loaded from the committing request or the held result.
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (cmd.load_now) begin
         rsp_data_in  = RSP_TDATA_W'(now_res);
         rsp_valid_in = 1'b1;
      end else if (cmd.load_held) begin
         rsp_data_in  = RSP_TDATA_W'(held_ff);
         rsp_valid_in = 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= NIL_PTR;
         cur_ff       <= NIL_PTR;
         free_ff      <= NIL_PTR;
         fresh_ff     <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         cur_ff       <= cur_in;
         free_ff      <= free_in;
         fresh_ff     <= fresh_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      val_ff      <= val_in;
      tmp_ff      <= tmp_in;
      new_ff      <= new_in;
      held_ff     <= held_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign stat.op       = op_ff;
   assign stat.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_tdata     = rsp_data_ff;

endmodule
